### rtl/hcr_pkg.sv
`default_nettype none

package hcr_pkg;

	localparam int RESP_W    = 49;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 10;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
	localparam int MIN_SIZE   = 5;
	localparam int MAX_HEIGHT = 4096;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic signed [RESP_W-1:0] response;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         column;
		logic                     frame_end;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic ld_s2;
		logic ld_s3;
	} grad_ctl_t;

	typedef struct packed {
		logic shift;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
	} blur_ctl_t;

endpackage

`default_nettype wire

### rtl/hcr_line_bank.sv
`default_nettype none

module hcr_line_bank #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/hcr_grad.sv
`default_nettype none

module hcr_grad #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  hcr_pkg::grad_ctl_t            ctl,
	input  logic [PIXEL_BITS-1:0]         top,
	input  logic [PIXEL_BITS-1:0]         mid,
	input  logic [PIXEL_BITS-1:0]         bot,
	output logic signed [2*PIXEL_BITS+5:0] xx,
	output logic signed [2*PIXEL_BITS+5:0] yy,
	output logic signed [2*PIXEL_BITS+5:0] xy
);
	import hcr_pkg::*;

	localparam int GW = PIXEL_BITS + 3;
	localparam int PW = 2 * GW;

	logic [PIXEL_BITS-1:0] t1_q, m1_q, b1_q, t2_q, m2_q, b2_q;
	logic signed [GW-1:0]  et, em, eb, et1, eb1, et2, em2, eb2;
	logic signed [GW-1:0]  gx, gy;
	logic signed [GW-1:0]  gx_s2, gy_s2;
	logic signed [PW-1:0]  xx_s3, yy_s3, xy_s3;

	// Column c is the incoming one; the two registers hold columns c-1 and c-2.
	always_comb begin
		et  = $signed({3'b000, top});
		em  = $signed({3'b000, mid});
		eb  = $signed({3'b000, bot});
		et1 = $signed({3'b000, t1_q});
		eb1 = $signed({3'b000, b1_q});
		et2 = $signed({3'b000, t2_q});
		em2 = $signed({3'b000, m2_q});
		eb2 = $signed({3'b000, b2_q});
		gx  = (et2 - et) + ((em2 - em) <<< 1) + (eb2 - eb);
		gy  = (et2 + (et1 <<< 1) + et) - (eb2 + (eb1 <<< 1) + eb);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			t1_q <= top;
			m1_q <= mid;
			b1_q <= bot;
			t2_q <= t1_q;
			m2_q <= m1_q;
			b2_q <= b1_q;
		end
		if (ctl.ld_s2) begin
			gx_s2 <= gx;
			gy_s2 <= gy;
		end
		if (ctl.ld_s3) begin
			xx_s3 <= PW'(gx_s2) * PW'(gx_s2);
			yy_s3 <= PW'(gy_s2) * PW'(gy_s2);
			xy_s3 <= PW'(gx_s2) * PW'(gy_s2);
		end
	end

	assign xx = xx_s3;
	assign yy = yy_s3;
	assign xy = xy_s3;

endmodule

`default_nettype wire

### rtl/hcr_blur.sv
`default_nettype none

module hcr_blur #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                          clk,
	input  hcr_pkg::blur_ctl_t            ctl,
	input  logic [6*PIXEL_BITS+17:0]      row_a,
	input  logic [6*PIXEL_BITS+17:0]      row_b,
	input  logic [6*PIXEL_BITS+17:0]      row_c,
	output logic signed [hcr_pkg::RESP_W-1:0] response
);
	import hcr_pkg::*;

	localparam int PW = 2 * (PIXEL_BITS + 3);
	localparam int VW = PW + 2;
	localparam int SW = PW + 4;
	localparam int DW = 2 * SW;

	logic signed [PW-1:0] a_xx, a_yy, a_xy, b_xx, b_yy, b_xy, c_xx, c_yy, c_xy;
	logic signed [VW-1:0] vxx, vyy, vxy;
	logic signed [VW-1:0] vxx_s5, vyy_s5, vxy_s5;
	logic signed [VW-1:0] hxx1_q, hyy1_q, hxy1_q, hxx2_q, hyy2_q, hxy2_q;
	logic signed [SW-1:0] sxx, syy, sxy;
	logic signed [SW-1:0] sxx_s6, syy_s6, sxy_s6;
	logic signed [DW-1:0] pa_s7, pb_s7;
	logic signed [DW-1:0] det;
	logic signed [RESP_W-1:0] resp_s8;

	always_comb begin
		a_xx = $signed(row_a[3*PW-1:2*PW]);
		a_yy = $signed(row_a[2*PW-1:PW]);
		a_xy = $signed(row_a[PW-1:0]);
		b_xx = $signed(row_b[3*PW-1:2*PW]);
		b_yy = $signed(row_b[2*PW-1:PW]);
		b_xy = $signed(row_b[PW-1:0]);
		c_xx = $signed(row_c[3*PW-1:2*PW]);
		c_yy = $signed(row_c[2*PW-1:PW]);
		c_xy = $signed(row_c[PW-1:0]);
		vxx = VW'(a_xx) + (VW'(b_xx) <<< 1) + VW'(c_xx);
		vyy = VW'(a_yy) + (VW'(b_yy) <<< 1) + VW'(c_yy);
		vxy = VW'(a_xy) + (VW'(b_xy) <<< 1) + VW'(c_xy);
		// The blur is separable: vertical sums first, then across three columns.
		sxx = SW'(hxx2_q) + (SW'(hxx1_q) <<< 1) + SW'(vxx_s5);
		syy = SW'(hyy2_q) + (SW'(hyy1_q) <<< 1) + SW'(vyy_s5);
		sxy = SW'(hxy2_q) + (SW'(hxy1_q) <<< 1) + SW'(vxy_s5);
		det = pa_s7 - pb_s7;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s5) begin
			vxx_s5 <= vxx;
			vyy_s5 <= vyy;
			vxy_s5 <= vxy;
		end
		if (ctl.shift) begin
			hxx1_q <= vxx_s5;
			hyy1_q <= vyy_s5;
			hxy1_q <= vxy_s5;
			hxx2_q <= hxx1_q;
			hyy2_q <= hyy1_q;
			hxy2_q <= hxy1_q;
		end
		if (ctl.ld_s6) begin
			sxx_s6 <= sxx;
			syy_s6 <= syy;
			sxy_s6 <= sxy;
		end
		if (ctl.ld_s7) begin
			pa_s7 <= DW'(sxx_s6) * DW'(syy_s6);
			pb_s7 <= DW'(sxy_s6) * DW'(sxy_s6);
		end
		if (ctl.ld_s8)
			resp_s8 <= det[RESP_W-1:0];
	end

	assign response = resp_s8;

endmodule

`default_nettype wire

### rtl/harris_corner_response_unit.sv
`default_nettype none

// Harris corner response over a raster stream of pixels: 3x3 Sobel gradients, their
// squares and cross product, a 3x3 binomial blur of each and det = Sxx*Syy - Sxy^2,
// all unnormalised (the response is 2^20 times the real value). One pixel is taken
// every clock while in_stall is low; the datapath is an eight-stage pipeline from
// acceptance to the output register, with three pixel line banks and three product
// line banks each giving one write and one registered read per cycle. The response
// of the pixel at (r, c) is computed as the pixel at (r+2, c+2) passes the stages;
// only pixels at least two from every edge produce a transaction. After reset every
// address of the line banks is cleared, and in_stall is held high until that is done.
module harris_corner_response_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  hcr_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output hcr_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [hcr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hcr_pkg::CFG_W-1:0]        cfg_data
);
	import hcr_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WEW = CW + 1;
	localparam int PW  = 2 * (PIXEL_BITS + 3);
	localparam int BW  = 3 * PW;

	typedef struct packed {
		logic             oflag;
		logic             fend;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
	} tag_t;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [ROW_W-1:0]    row_q;
	logic [CW-1:0]       col_q;
	logic [1:0]          mod_q;
	logic                clr_q;
	logic [CW-1:0]       clr_addr_q;

	logic [8:1] vld_q;
	logic [8:1] ld;
	logic       acc;

	logic [31:0]          w32, h32, cm2;
	logic [WEW-1:0]       w_eff, c_inc;
	logic [HEIGHT_W-1:0]  h_eff, r_inc;
	logic [ROW_W-1:0]     r, r_nx;
	logic [CW-1:0]        c, c_nx;
	logic [1:0]           m, m_nx;
	logic [PIXEL_BITS-1:0] pix_in;
	tag_t                 tag_in;
	logic                 pflag_in;

	logic [PIXEL_BITS-1:0] pix_s1;
	logic [1:0]            m_s1, m_s2, m_s3, m_s4;
	logic [CW-1:0]         pcol_s1, pcol_s2, pcol_s3;
	logic                  pflag_s1, pflag_s2, pflag_s3;
	tag_t                  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [BW-1:0]         prod_s4;

	logic [PIXEL_BITS-1:0] pix_rd [3];
	logic [PIXEL_BITS-1:0] top, mid;
	logic [BW-1:0]         prod_rd [3];
	logic [BW-1:0]         row_a, row_b;
	logic signed [PW-1:0]  xx, yy, xy;
	logic [1:0]            pm_wr;
	logic signed [RESP_W-1:0] response;

	grad_ctl_t gctl;
	blur_ctl_t bctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == CW'(MAX_WIDTH - 1))
				clr_q <= 1'b0;
		end
	end

	// Stage k may load when it is empty or its occupant moves on.
	always_comb begin
		ld[8] = !(vld_q[8] && tag_s8.oflag) || !out_stall;
		for (int k = 7; k >= 1; k--)
			ld[k] = !vld_q[k] || ld[k+1];
	end

	assign in_stall = clr_q || !ld[1];
	assign acc      = in_valid && !in_stall;

	always_comb begin
		w32 = 32'(width_q);
		h32 = 32'(height_q);
		if (w32 < MIN_SIZE)
			w_eff = WEW'(MIN_SIZE);
		else if (w32 > MAX_WIDTH)
			w_eff = WEW'(MAX_WIDTH);
		else
			w_eff = w32[WEW-1:0];
		if (h32 < MIN_SIZE)
			h_eff = HEIGHT_W'(MIN_SIZE);
		else if (h32 > MAX_HEIGHT)
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		else
			h_eff = height_q;

		if (in_item.frame_start) begin
			r = '0;
			c = '0;
			m = 2'd0;
		end else begin
			r = row_q;
			c = col_q;
			m = mod_q;
		end

		c_inc = {1'b0, c} + 1'b1;
		r_inc = {1'b0, r} + 1'b1;
		if (c_inc >= w_eff) begin
			c_nx = '0;
			if (r_inc >= h_eff) begin
				r_nx = '0;
				m_nx = 2'd0;
			end else begin
				r_nx = r_inc[ROW_W-1:0];
				m_nx = (m == 2'd2) ? 2'd0 : m + 2'd1;
			end
		end else begin
			c_nx = c_inc[CW-1:0];
			r_nx = r;
			m_nx = m;
		end

		pix_in        = PIXEL_BITS'(32'(in_item.pixel));
		pflag_in      = (r >= ROW_W'(2)) && (32'(c) >= 32'd2);
		cm2           = 32'(c) - 32'd2;
		tag_in.oflag  = (r >= ROW_W'(4)) && (32'(c) >= 32'd4) &&
		                ({1'b0, r} < h_eff) && ({1'b0, c} < w_eff);
		tag_in.fend   = ({1'b0, r} == h_eff - 1'b1) && ({1'b0, c} == w_eff - 1'b1);
		tag_in.row    = r - ROW_W'(2);
		tag_in.column = cm2[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			mod_q <= 2'd0;
		end else if (acc) begin
			row_q <= r_nx;
			col_q <= c_nx;
			mod_q <= m_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[1])
				vld_q[1] <= acc;
			for (int k = 2; k <= 8; k++)
				if (ld[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pix_s1   <= pix_in;
			m_s1     <= m;
			pcol_s1  <= c - 1'b1;
			pflag_s1 <= pflag_in;
			tag_s1   <= tag_in;
		end
		if (ld[2]) begin
			m_s2     <= m_s1;
			pcol_s2  <= pcol_s1;
			pflag_s2 <= pflag_s1;
			tag_s2   <= tag_s1;
		end
		if (ld[3]) begin
			m_s3     <= m_s2;
			pcol_s3  <= pcol_s2;
			pflag_s3 <= pflag_s2;
			tag_s3   <= tag_s2;
		end
		if (ld[4]) begin
			m_s4    <= m_s3;
			tag_s4  <= tag_s3;
			prod_s4 <= {xx, yy, xy};
		end
		if (ld[5])
			tag_s5 <= tag_s4;
		if (ld[6])
			tag_s6 <= tag_s5;
		if (ld[7])
			tag_s7 <= tag_s6;
		if (ld[8])
			tag_s8 <= tag_s7;
	end

	// Bank m takes the incoming row; the other two hold rows r-2 and r-1.
	for (genvar b = 0; b < 3; b++) begin : g_pix_bank
		hcr_line_bank #(
			.DEPTH(MAX_WIDTH),
			.WIDTH(PIXEL_BITS)
		) u_bank (
			.clk  (clk),
			.we   (clr_q || (acc && m == 2'(b))),
			.waddr(clr_q ? clr_addr_q : c),
			.wdata(clr_q ? '0 : pix_in),
			.re   (ld[1]),
			.raddr(c),
			.rdata(pix_rd[b])
		);
	end

	always_comb begin
		case (m_s1)
			2'd1: begin
				top = pix_rd[2];
				mid = pix_rd[0];
			end
			2'd2: begin
				top = pix_rd[0];
				mid = pix_rd[1];
			end
			default: begin
				top = pix_rd[1];
				mid = pix_rd[2];
			end
		endcase
	end

	assign gctl.shift = ld[2] && vld_q[1];
	assign gctl.ld_s2 = ld[2];
	assign gctl.ld_s3 = ld[3];

	hcr_grad #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_grad (
		.clk(clk),
		.ctl(gctl),
		.top(top),
		.mid(mid),
		.bot(pix_s1),
		.xx (xx),
		.yy (yy),
		.xy (xy)
	);

	// Products of row r-1 go to bank (m+2) mod 3; banks m and m+1 hold rows r-3 and r-2.
	assign pm_wr = (m_s3 == 2'd0) ? 2'd2 : m_s3 - 2'd1;

	for (genvar b = 0; b < 3; b++) begin : g_prod_bank
		hcr_line_bank #(
			.DEPTH(MAX_WIDTH),
			.WIDTH(BW)
		) u_bank (
			.clk  (clk),
			.we   (clr_q || (ld[4] && vld_q[3] && pflag_s3 && pm_wr == 2'(b))),
			.waddr(clr_q ? clr_addr_q : pcol_s3),
			.wdata(clr_q ? '0 : {xx, yy, xy}),
			.re   (ld[4]),
			.raddr(pcol_s3),
			.rdata(prod_rd[b])
		);
	end

	always_comb begin
		case (m_s4)
			2'd1: begin
				row_a = prod_rd[1];
				row_b = prod_rd[2];
			end
			2'd2: begin
				row_a = prod_rd[2];
				row_b = prod_rd[0];
			end
			default: begin
				row_a = prod_rd[0];
				row_b = prod_rd[1];
			end
		endcase
	end

	assign bctl.shift = ld[6] && vld_q[5];
	assign bctl.ld_s5 = ld[5];
	assign bctl.ld_s6 = ld[6];
	assign bctl.ld_s7 = ld[7];
	assign bctl.ld_s8 = ld[8];

	hcr_blur #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_blur (
		.clk     (clk),
		.ctl     (bctl),
		.row_a   (row_a),
		.row_b   (row_b),
		.row_c   (prod_s4),
		.response(response)
	);

	assign out_valid          = vld_q[8] && tag_s8.oflag;
	assign out_item.response  = response;
	assign out_item.row       = tag_s8.row;
	assign out_item.column    = tag_s8.column;
	assign out_item.frame_end = tag_s8.fend;

`ifndef SYNTHESIS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> in_stall)
		else $error("item accepted during line bank clearing");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |=> !clr_q)
		else $error("line bank clearing restarted");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_WIDTH && mod_q != 2'd3)
		else $error("position counter out of range");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && out_valid && out_stall |-> in_stall)
		else $error("full pipeline took an item while the output was held");
`endif

endmodule

`default_nettype wire

### tb/harris_corner_response_unit_test.sv
`timescale 1ns / 1ps

module harris_corner_response_unit_test;
	import hcr_pkg::*;

	localparam int LINE_LEN      = 1024;
	localparam int DRAIN_CYCLES  = 24;
	localparam int WATCHDOG_MAX  = 20000;
	localparam int HOLD_OFF_LEN  = 300;

	typedef struct {
		logic [7:0] pixel;
		logic       frame_start;
		bit         typed;
		out_item_t  typed_result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	harris_corner_response_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Shadow of the block: registers, line stores and raster position.
	logic [WIDTH_W-1:0] width_reg;
	logic [HEIGHT_W-1:0] height_reg;
	int pixel_rows[3][LINE_LEN];
	longint grad_xx[3][LINE_LEN];
	longint grad_yy[3][LINE_LEN];
	longint grad_xy[3][LINE_LEN];
	int next_row;
	int next_col;

	out_item_t pending_responses[$];
	int error_count;
	int idle_pct;
	int stall_pct;
	int restart_pct;
	bit hold_request;
	int hold_left;
	int quiet_cycles;

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bit corner_response(in_item_t it, output out_item_t res);
		int w, h, r, c, t, m, b, i, j;
		longint gx, gy, sxx, syy, sxy, k, det;
		bit emit;
		w = clamp(int'(width_reg), MIN_SIZE, LINE_LEN);
		h = clamp(int'(height_reg), MIN_SIZE, MAX_HEIGHT);
		emit = 1'b0;
		res = '0;
		if (it.frame_start) begin
			r = 0;
			c = 0;
		end else begin
			r = next_row;
			c = next_col;
		end
		if (c >= LINE_LEN)
			c = 0;
		pixel_rows[r % 3][c] = int'(it.pixel);
		if (r >= 2 && c >= 2) begin
			t = (r - 2) % 3;
			m = (r - 1) % 3;
			b = r % 3;
			gx = (pixel_rows[t][c-2] - pixel_rows[t][c])
				+ 2 * (pixel_rows[m][c-2] - pixel_rows[m][c])
				+ (pixel_rows[b][c-2] - pixel_rows[b][c]);
			gy = (pixel_rows[t][c-2] + 2 * pixel_rows[t][c-1] + pixel_rows[t][c])
				- (pixel_rows[b][c-2] + 2 * pixel_rows[b][c-1] + pixel_rows[b][c]);
			grad_xx[(r - 1) % 3][c-1] = gx * gx;
			grad_yy[(r - 1) % 3][c-1] = gy * gy;
			grad_xy[(r - 1) % 3][c-1] = gx * gy;
		end
		if (r >= 4 && c >= 4 && r < h && c < w) begin
			sxx = 0;
			syy = 0;
			sxy = 0;
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++) begin
					k = (i == 1 ? 2 : 1) * (j == 1 ? 2 : 1);
					sxx += k * grad_xx[(r - 3 + i) % 3][c-3+j];
					syy += k * grad_yy[(r - 3 + i) % 3][c-3+j];
					sxy += k * grad_xy[(r - 3 + i) % 3][c-3+j];
				end
			det = sxx * syy - sxy * sxy;
			res.response = det[RESP_W-1:0];
			res.row = ROW_W'(r - 2);
			res.column = COL_W'(c - 2);
			res.frame_end = (r == h - 1 && c == w - 1);
			emit = 1'b1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_row = r;
		next_col = c;
		return emit;
	endfunction

	// Offers one pixel, waits for the transaction, and records what it should produce.
	task automatic send_pixel(in_item_t it, bit typed, out_item_t typed_result);
		out_item_t res;
		bit emit;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		emit = corner_response(it, res);
		if (typed)
			pending_responses.push_back(typed_result);
		else if (emit)
			pending_responses.push_back(res);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH)
			width_reg = value[WIDTH_W-1:0];
		else
			height_reg = value[HEIGHT_W-1:0];
	endtask

	// Frames of random content: noise, hard quadrant corners or gentle ramps.
	task automatic run_frames(int count, int w, int h);
		int pos, mode, r, c, i;
		in_item_t it;
		pos = 0;
		mode = 0;
		for (i = 0; i < count; i++) begin
			if (pos == 0) begin
				mode = $urandom_range(2);
				it.frame_start = ($urandom_range(9) != 0);
			end else begin
				it.frame_start = ($urandom_range(99) < restart_pct);
				if (it.frame_start)
					pos = 0;
			end
			r = pos / w;
			c = pos % w;
			case (mode)
				0: it.pixel = 8'($urandom);
				1: it.pixel = ((r < h / 2) ^ (c < w / 2)) ? 8'hFF : 8'h00;
				default: it.pixel = 8'(r * 37 + c * 11 + $urandom_range(3));
			endcase
			send_pixel(it, 1'b0, '0);
			pos++;
			if (pos >= w * h)
				pos = 0;
		end
		settle();
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_OFF_LEN;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, out_item);
				error_count++;
			end else begin
				want = pending_responses.pop_front();
				if (out_item.response !== want.response || out_item.row !== want.row
					|| out_item.column !== want.column
					|| out_item.frame_end !== want.frame_end) begin
					$display("%0t: mismatch, expected %p, actual %p", $time, want, out_item);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0)
			|| (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("%0t: timeout with %0d responses outstanding", $time,
				pending_responses.size());
			$display("harris_corner_response_unit_test NOT OK");
			$finish;
		end
	end

	stim_row_t flat_frame[25];

	initial begin
		int i;
		error_count = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		restart_pct = 2;
		hold_request = 1'b0;
		hold_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		next_row = 0;
		next_col = 0;
		for (i = 0; i < 3 * LINE_LEN; i++) begin
			pixel_rows[i / LINE_LEN][i % LINE_LEN] = 0;
			grad_xx[i / LINE_LEN][i % LINE_LEN] = 0;
			grad_yy[i / LINE_LEN][i % LINE_LEN] = 0;
			grad_xy[i / LINE_LEN][i % LINE_LEN] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// A flat white 5x5 frame has no gradient, so its only response is zero at the
		// centre, and that is also the last of the frame.
		for (i = 0; i < 25; i++) begin
			flat_frame[i].pixel = 8'hFF;
			flat_frame[i].frame_start = (i == 0);
			flat_frame[i].typed = (i == 24);
			flat_frame[i].typed_result = '{response: '0, row: 12'd2, column: 10'd2,
				frame_end: 1'b1};
		end
		write_reg(CFG_IMAGE_WIDTH, 13'd5);
		write_reg(CFG_IMAGE_HEIGHT, 13'd5);
		foreach (flat_frame[n])
			send_pixel('{pixel: flat_frame[n].pixel, frame_start: flat_frame[n].frame_start},
				flat_frame[n].typed, flat_frame[n].typed_result);
		settle();

		// Sizes below the minimum saturate to five.
		write_reg(CFG_IMAGE_WIDTH, 13'd0);
		write_reg(CFG_IMAGE_HEIGHT, 13'd0);
		run_frames(120, 5, 5);

		idle_pct = 52;
		write_reg(CFG_IMAGE_WIDTH, 13'd8);
		write_reg(CFG_IMAGE_HEIGHT, 13'd6);
		run_frames(130, 8, 6);

		// Widest line, by saturation of an oversized width: the first rows give nothing.
		idle_pct = 0;
		write_reg(CFG_IMAGE_WIDTH, 13'h07FF);
		write_reg(CFG_IMAGE_HEIGHT, 13'd5);
		run_frames(100, LINE_LEN, 5);

		stall_pct = 52;
		write_reg(CFG_IMAGE_WIDTH, 13'd7);
		write_reg(CFG_IMAGE_HEIGHT, 13'd9);
		run_frames(120, 7, 9);

		// The receiver holds off while pixels keep coming, so the pipeline backs up.
		// No frame is cut short here, so responses are sure to arrive during the hold.
		stall_pct = 0;
		restart_pct = 0;
		write_reg(CFG_IMAGE_WIDTH, 13'd13);
		write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
		hold_request = 1'b1;
		run_frames(160, 13, 4096);
		restart_pct = 2;

		// Left mid frame: the smaller size takes over from the old position.
		idle_pct = 11;
		stall_pct = 11;
		write_reg(CFG_IMAGE_WIDTH, 13'd6);
		write_reg(CFG_IMAGE_HEIGHT, 13'd7);
		run_frames(110, 6, 7);

		idle_pct = 0;
		stall_pct = 0;
		write_reg(CFG_IMAGE_WIDTH, 13'd11);
		write_reg(CFG_IMAGE_HEIGHT, 13'd10);
		run_frames(90, 11, 10);

		if (error_count == 0)
			$display("harris_corner_response_unit_test OK");
		else
			$display("harris_corner_response_unit_test NOT OK");
		$finish;
	end

endmodule

### sim.f
rtl/hcr_pkg.sv
rtl/hcr_line_bank.sv
rtl/hcr_grad.sv
rtl/hcr_blur.sv
rtl/harris_corner_response_unit.sv
tb/harris_corner_response_unit_test.sv
